### design/fprc_pkg.sv
`default_nettype none
package fprc_pkg;

  localparam int unsigned SIG_W  = 16;  // Q7.8 signal and gain width
  localparam int unsigned LIM_W  = 15;  // integral bound width
  localparam int unsigned ERR_W  = 17;  // target minus measured
  localparam int unsigned INT_W  = 24;  // stored integral, Q.16, bound below 2^23
  localparam int unsigned MA_W   = 17;  // multiplier operand a
  localparam int unsigned MB_W   = 24;  // multiplier operand b
  localparam int unsigned PROD_W = MA_W + MB_W;
  localparam int unsigned ACC_W  = 44;  // Q.24 total
  localparam int unsigned CMD_W  = ACC_W - 16;
  localparam int unsigned IDX_W  = 3;

  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
  localparam logic [IDX_W-1:0] REG_FF_ACCEL_GAIN = 3'd2;
  localparam logic [IDX_W-1:0] REG_FF_AIL_GAIN   = 3'd3;
  localparam logic [IDX_W-1:0] REG_RUDDER_HIGH   = 3'd4;
  localparam logic [IDX_W-1:0] REG_RUDDER_LOW    = 3'd5;
  localparam logic [IDX_W-1:0] REG_INTEG_LIMIT   = 3'd6;
  localparam logic [IDX_W-1:0] REG_TARGET_ACCEL  = 3'd7;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,     // acc = (prod << 8) + half LSB of Q.8
    ACC_ADD_SHL,  // acc += prod << 8
    ACC_ADD       // acc += prod
  } acc_op_e;

  typedef struct packed {
    logic    mul_en;
    acc_op_e acc_op;
  } fprc_ctrl_t;

endpackage
`default_nettype wire

### design/fprc_in_if.sv
`default_nettype none
interface fprc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] reference_accel;
  logic signed [15:0] aileron_angle;
  logic signed [15:0] measured_accel;
  logic        [15:0] elapsed_time;

  modport source (
    output valid, reference_accel, aileron_angle, measured_accel, elapsed_time,
    input  ready
  );
  modport sink (
    input  valid, reference_accel, aileron_angle, measured_accel, elapsed_time,
    output ready
  );
endinterface
`default_nettype wire

### design/fprc_out_if.sv
`default_nettype none
interface fprc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] rudder_command;
  logic               output_clamped;

  modport source (
    output valid, rudder_command, output_clamped,
    input  ready
  );
  modport sink (
    input  valid, rudder_command, output_clamped,
    output ready
  );
endinterface
`default_nettype wire

### design/fprc_mac.sv
`default_nettype none
module fprc_mac (
  input  wire logic                                 clk_i,
  input  wire fprc_pkg::fprc_ctrl_t                 ctrl_i,
  input  wire logic signed [fprc_pkg::MA_W-1:0]     a_i,
  input  wire logic signed [fprc_pkg::MB_W-1:0]     b_i,
  output      logic signed [fprc_pkg::PROD_W-1:0]   prod_o,
  output      logic signed [fprc_pkg::ACC_W-1:0]    acc_o
);
  import fprc_pkg::*;

  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [ACC_W-1:0]  acc_d, acc_q;
  logic        [ACC_W-1:0]  prod_shl, prod_ext;

  assign prod_d = a_i * b_i;

  // shifted products (gain times Q7.8 signal) stay below 2^32, so the top bits are pure sign
  assign prod_shl = {prod_q[ACC_W-9:0], 8'b0};
  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_comb begin
    case (ctrl_i.acc_op)
      ACC_LOAD:    acc_d = $signed(prod_shl + ROUND_HALF);
      ACC_ADD_SHL: acc_d = acc_q + $signed(prod_shl);
      ACC_ADD:     acc_d = acc_q + $signed(prod_ext);
      default:     acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
    acc_q <= acc_d;
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;

endmodule
`default_nettype wire

### design/feedforward_pi_rudder_control.sv
// A request with nonzero elapsed time runs the sequencer through its product,
// accumulate and output steps; a held result stalls the sequencer in its output step.
// A request with zero elapsed time is taken and gives no result.
// A new request is taken only in idle, after the result of the last one is loaded;
// the single 17x24 multiplier computes the five products of a tick in turn.
// Reset: asynchronous, active low; configuration registers return to their defaults,
// the sequencer and the output valid clear, and the error integral clears to zero.
`default_nettype none
module feedforward_pi_rudder_control (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  fprc_in_if.sink                           in_if,
  fprc_out_if.source                        out_if,
  input  wire logic                         cfg_we_i,
  input  wire logic [fprc_pkg::IDX_W-1:0]   cfg_idx_i,
  input  wire logic [fprc_pkg::SIG_W-1:0]   cfg_wdata_i
);
  import fprc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MI   = 3'd1;  // err * dt
  localparam logic [2:0] S_INT  = 3'd2;  // integral update, ffa * ref
  localparam logic [2:0] S_F2   = 3'd3;  // ffl * ail
  localparam logic [2:0] S_P    = 3'd4;  // kp * err
  localparam logic [2:0] S_I    = 3'd5;  // ki * integral
  localparam logic [2:0] S_RND  = 3'd6;  // last accumulate
  localparam logic [2:0] S_OUT  = 3'd7;  // round, clamp, load output

  logic [2:0] state_q, state_d;

  // configuration
  logic signed [SIG_W-1:0] kp_q, ki_q, ffa_q, ffl_q, hi_q, lo_q, target_q;
  logic        [LIM_W-1:0] ilim_q;

  // captured request
  logic signed [SIG_W-1:0] ref_q, ail_q;
  logic        [SIG_W-1:0] dt_q;
  logic signed [ERR_W-1:0] err_q;

  logic signed [INT_W-1:0] integ_q, integ_d;

  logic                    out_valid_q;
  logic signed [SIG_W-1:0] out_cmd_q;
  logic                    out_clamped_q;

  fprc_ctrl_t               ctrl;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  logic in_acc, out_load;

  assign in_if.ready = (state_q == S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || out_if.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q     <= 16'sd128;
      ki_q     <= 16'sd26;
      ffa_q    <= 16'sd256;
      ffl_q    <= 16'sd256;
      hi_q     <= 16'sd256;
      lo_q     <= -16'sd256;
      ilim_q   <= 15'd2560;
      target_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PROP_GAIN:     kp_q     <= cfg_wdata_i;
        REG_INTEG_GAIN:    ki_q     <= cfg_wdata_i;
        REG_FF_ACCEL_GAIN: ffa_q    <= cfg_wdata_i;
        REG_FF_AIL_GAIN:   ffl_q    <= cfg_wdata_i;
        REG_RUDDER_HIGH:   hi_q     <= cfg_wdata_i;
        REG_RUDDER_LOW:    lo_q     <= cfg_wdata_i;
        REG_INTEG_LIMIT:   ilim_q   <= cfg_wdata_i[LIM_W-1:0];
        REG_TARGET_ACCEL:  target_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc && (in_if.elapsed_time != '0)) state_d = S_MI;
      S_MI:    state_d = S_INT;
      S_INT:   state_d = S_F2;
      S_F2:    state_d = S_P;
      S_P:     state_d = S_I;
      S_I:     state_d = S_RND;
      S_RND:   state_d = S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ref_q <= in_if.reference_accel;
      ail_q <= in_if.aileron_angle;
      dt_q  <= in_if.elapsed_time;
      err_q <= ERR_W'(target_q) - ERR_W'(in_if.measured_accel);
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MI:  begin mul_a = err_q;       mul_b = $signed({8'b0, dt_q}); end
      S_INT: begin mul_a = MA_W'(ffa_q); mul_b = MB_W'(ref_q); end
      S_F2:  begin mul_a = MA_W'(ffl_q); mul_b = MB_W'(ail_q); end
      S_P:   begin mul_a = MA_W'(kp_q);  mul_b = MB_W'(err_q); end
      S_I:   begin mul_a = MA_W'(ki_q);  mul_b = integ_q; end
      default: ;
    endcase
  end

  always_comb begin
    ctrl.mul_en = (state_q == S_MI) || (state_q == S_INT) || (state_q == S_F2) ||
                  (state_q == S_P) || (state_q == S_I);
    case (state_q)
      S_F2:    ctrl.acc_op = ACC_LOAD;
      S_P:     ctrl.acc_op = ACC_ADD_SHL;
      S_I:     ctrl.acc_op = ACC_ADD_SHL;
      S_RND:   ctrl.acc_op = ACC_ADD;
      default: ctrl.acc_op = ACC_HOLD;
    endcase
  end

  fprc_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod),
    .acc_o  (acc)
  );

  // integral update: floor(err*dt / 256) added, then clamped to +/- limit
  logic signed [INT_W+1:0] integ_sum, lim_pos, lim_neg;

  assign integ_sum = (INT_W+2)'(integ_q) + prod[INT_W+9:8];
  assign lim_pos   = $signed({3'b0, ilim_q, 8'b0});
  assign lim_neg   = -lim_pos;

  always_comb begin
    if (integ_sum > lim_pos) begin
      integ_d = INT_W'(lim_pos);
    end else if (integ_sum < lim_neg) begin
      integ_d = INT_W'(lim_neg);
    end else begin
      integ_d = INT_W'(integ_sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else if (state_q == S_INT) begin
      integ_q <= integ_d;
    end
  end

  // round half up is done by the half LSB preloaded into the accumulator
  logic signed [CMD_W-1:0] cmd, hi_ext, lo_ext;
  logic signed [SIG_W-1:0] cmd_sel;
  logic                    clamp_sel;

  assign cmd    = acc[ACC_W-1:16];
  assign hi_ext = CMD_W'(hi_q);
  assign lo_ext = CMD_W'(lo_q);

  always_comb begin
    if (cmd > hi_ext) begin
      cmd_sel   = hi_q;
      clamp_sel = 1'b1;
    end else if (cmd < lo_ext) begin
      cmd_sel   = lo_q;
      clamp_sel = 1'b1;
    end else begin
      cmd_sel   = cmd[SIG_W-1:0];
      clamp_sel = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_cmd_q     <= cmd_sel;
      out_clamped_q <= clamp_sel;
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.rudder_command = out_cmd_q;
  assign out_if.output_clamped = out_clamped_q;

`ifndef SYNTHESIS
  a_zero_dt_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_if.elapsed_time == '0) |=> (state_q == S_IDLE) && $stable(integ_q))
    else $error("zero elapsed time request started work or moved the integral");

  a_nonzero_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_if.elapsed_time != '0) |=> (state_q == S_MI))
    else $error("request with elapsed time did not start the sequence");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result appeared without passing the output step");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) && out_valid_q && !out_if.ready |=> (state_q == S_OUT))
    else $error("finished result dropped while output slot busy");

  a_clamp_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_clamped_q |-> (out_cmd_q == hi_q) || (out_cmd_q == lo_q))
    else $error("clamped flag set on a value that is no rudder limit");
`endif

endmodule
`default_nettype wire
